/* sv/hrp_pkg.sv */
// Shared types, constants and helpers for the HTTP response parser.
// Used by hrp_core and http_response_parser_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hrp_pkg;

    // Character constants
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    localparam logic [2:0] PREFIX_LEN = 3'd5;
    localparam logic [9:0] CODE_MAX   = 10'd999;

    // Parser phases
    typedef enum logic [3:0] {
        PH_PREFIX     = 4'd0,
        PH_VERSION    = 4'd1,
        PH_TO_SPACE   = 4'd2,
        PH_CODE       = 4'd3,
        PH_STATUS_LF  = 4'd4,
        PH_LINE_START = 4'd5,
        PH_KEY        = 4'd6,
        PH_SKIP_ONE   = 4'd7,
        PH_VALUE      = 4'd8,
        PH_VALUE_LF   = 4'd9,
        PH_FINAL_LF   = 4'd10,
        PH_BODY       = 4'd11,
        PH_ERROR      = 4'd12
    } t_phase;

    // Byte classes
    typedef enum logic [2:0] {
        CL_STATUS = 3'd0,
        CL_KEY    = 3'd1,
        CL_VALUE  = 3'd2,
        CL_DELIM  = 3'd3,
        CL_BODY   = 3'd4,
        CL_ERROR  = 3'd5
    } t_class;

    // Message outcome codes
    typedef enum logic [1:0] {
        OC_BUSY  = 2'd0,
        OC_OK    = 2'd1,
        OC_ERROR = 2'd2
    } t_outcome;

    // One result item
    typedef struct packed {
        logic [1:0] outcome;
        logic       headers_done;
        logic [9:0] status_code;
        logic [3:0] version_digit;
        logic [2:0] byte_class;
        logic [7:0] echo_byte;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);
    localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // Expected "HTTP/" character at a prefix position
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

/* sv/http_response_parser_unit.sv */
// Top level of the HTTP response parser: input register, parser core and
// result register. Depends on hrp_pkg and hrp_core.
//
//  Channel   | Direction | tdata                          | tlast
//  ----------+-----------+--------------------------------+-----------
//  s_axis    | in        | data_byte [7:0]                | last_byte
//  m_axis    | out       | see m_axis_tdata comment       | -
//
// One byte is taken per cycle while the output is not stalled, and each byte's
// result is presented when the result register loads, after the byte has passed
// through the input register. The parser core updates its phase once per byte.
// Reset (synchronous, active low) empties both registers and puts the
// parser at the start of a message. A stalled output holds its result,
// and the input register keeps accepting until it too is full.
`timescale 1ns / 1ps
`default_nettype none

module http_response_parser_unit import hrp_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  wire                    s_axis_tlast,   // last_byte
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // [7:0] echo_byte, [10:8] byte_class, [14:11] version_digit,
    // [24:15] status_code, [25] headers_done, [27:26] outcome, rest zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic       w_out_free;
    logic       w_advance;
    t_result    w_result;

    // Handshake: move the held byte when the result register is free
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    hrp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_result    (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, r_out};

endmodule

`default_nettype wire

/* sv/hrp_core.sv */
// Parser state machine: phase and field registers, per-byte next state
// and result fields. Depends on hrp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hrp_core import hrp_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_advance,
    input  wire  [7:0] i_data_byte,
    input  wire        i_last_byte,
    output t_result    o_result
);

    t_phase     r_phase,  n_phase;
    logic [2:0] r_pos,    n_pos;
    logic [3:0] r_ver,    n_ver;
    logic [9:0] r_code,   n_code;
    logic       r_open,   n_open;
    t_class     w_class;

    logic        w_is_digit;
    logic [7:0]  w_diff;
    logic [3:0]  w_digit;
    logic [13:0] w_code_x10;
    logic        w_done;

    // Digit decode and code accumulation
    assign w_is_digit = (i_data_byte >= CHAR_ZERO) && (i_data_byte <= CHAR_NINE);
    assign w_diff     = i_data_byte - CHAR_ZERO;
    assign w_digit    = w_diff[3:0];
    assign w_code_x10 = ({4'b0, r_code} << 3) + ({4'b0, r_code} << 1) + {10'b0, w_digit};

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_ver   = r_ver;
        n_code  = r_code;
        n_open  = r_open;
        w_class = CL_STATUS;
        unique case (r_phase)
            PH_PREFIX: begin
                w_class = CL_STATUS;
                if (r_pos >= PREFIX_LEN || i_data_byte != prefix_char(r_pos)) begin
                    n_phase = PH_ERROR;
                end else begin
                    n_pos = r_pos + 3'd1;
                    if (n_pos == PREFIX_LEN) begin
                        n_phase = PH_VERSION;
                    end
                end
            end
            PH_VERSION: begin
                w_class = CL_STATUS;
                if (w_is_digit) begin
                    n_ver   = w_digit;
                    n_phase = PH_TO_SPACE;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_TO_SPACE: begin
                if (i_data_byte == CHAR_SPACE) begin
                    w_class = CL_DELIM;
                    n_phase = PH_CODE;
                end else begin
                    w_class = CL_STATUS;
                end
            end
            PH_CODE: begin
                if (i_data_byte == CHAR_CR) begin
                    w_class = CL_DELIM;
                    n_open  = 1'b0;
                    n_phase = PH_STATUS_LF;
                end else begin
                    w_class = CL_STATUS;
                    if (r_open && w_is_digit) begin
                        n_code = (w_code_x10 > {4'b0, CODE_MAX}) ? CODE_MAX
                                                                 : w_code_x10[9:0];
                    end else begin
                        n_open = 1'b0;
                    end
                end
            end
            PH_STATUS_LF: begin
                w_class = CL_DELIM;
                n_phase = (i_data_byte == CHAR_LF) ? PH_LINE_START : PH_ERROR;
            end
            PH_LINE_START: begin
                if (i_data_byte == CHAR_CR) begin
                    w_class = CL_DELIM;
                    n_phase = PH_FINAL_LF;
                end else if (i_data_byte == CHAR_COLON) begin
                    w_class = CL_DELIM;
                    n_phase = PH_SKIP_ONE;
                end else begin
                    w_class = CL_KEY;
                    n_phase = PH_KEY;
                end
            end
            PH_KEY: begin
                if (i_data_byte == CHAR_COLON) begin
                    w_class = CL_DELIM;
                    n_phase = PH_SKIP_ONE;
                end else begin
                    w_class = CL_KEY;
                end
            end
            PH_SKIP_ONE: begin
                w_class = CL_DELIM;
                n_phase = PH_VALUE;
            end
            PH_VALUE: begin
                if (i_data_byte == CHAR_CR) begin
                    w_class = CL_DELIM;
                    n_phase = PH_VALUE_LF;
                end else begin
                    w_class = CL_VALUE;
                end
            end
            PH_VALUE_LF: begin
                w_class = CL_DELIM;
                n_phase = PH_LINE_START;
            end
            PH_FINAL_LF: begin
                w_class = CL_DELIM;
                n_phase = (i_data_byte == CHAR_LF) ? PH_BODY : PH_ERROR;
            end
            PH_BODY: begin
                w_class = CL_BODY;
            end
            default: begin
                w_class = CL_ERROR;
                n_phase = PH_ERROR;
            end
        endcase
    end

    // Result fields from the updated state
    always_comb begin
        w_done                 = (n_phase == PH_BODY);
        o_result.echo_byte     = i_data_byte;
        o_result.byte_class    = w_class;
        o_result.version_digit = n_ver;
        o_result.status_code   = n_code;
        o_result.headers_done  = w_done;
        if (n_phase == PH_ERROR) begin
            o_result.outcome = OC_ERROR;
        end else if (i_last_byte) begin
            o_result.outcome = w_done ? OC_OK : OC_ERROR;
        end else begin
            o_result.outcome = OC_BUSY;
        end
    end

    // Advance state per transfer; return to start after the final byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_last_byte)) begin
            r_phase <= PH_PREFIX;
            r_pos   <= 3'd0;
            r_ver   <= 4'd0;
            r_code  <= 10'd0;
            r_open  <= 1'b1;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_ver   <= n_ver;
            r_code  <= n_code;
            r_open  <= n_open;
        end
    end

endmodule

`default_nettype wire
